// File: hw/rtl/mzd_pkg.sv
// Shared types, constants and a helper function for the maze door set merge block.
// Depends on nothing; every other file of the block but mzd_ram imports it.
package mzd_pkg;

  // Cell store geometry.
  localparam int MAX_CELLS = 1024;
  localparam int CELL_AW   = $clog2(MAX_CELLS);
  localparam int CNT_W     = CELL_AW + 1;

  // Field widths.
  localparam int POS_W   = 10;
  localparam int LABEL_W = 10;
  localparam int DIM_W   = 6;
  localparam int DIM_MAX = 32;
  localparam int PROD_W  = 2 * DIM_W;
  localparam int SUM_W   = CNT_W + DIM_W;

  // Step counter width of the remainder unit: one step per dividend bit.
  localparam int REM_STEP_W = $clog2(POS_W + 1);

  // Door store: one bit each for the right and the bottom door of a cell.
  localparam int DOOR_W = 2;
  localparam logic [DOOR_W-1:0] DOOR_MASK_RIGHT  = 2'b01;
  localparam logic [DOOR_W-1:0] DOOR_MASK_BOTTOM = 2'b10;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  // Command codes.
  localparam logic CMD_OPEN  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    DIR_TOP,
    DIR_RIGHT,
    DIR_BOTTOM,
    DIR_LEFT
  } dir_t;

  typedef struct packed {
    logic             cmd;
    logic [POS_W-1:0] cell_pos;
    dir_t             move_dir;
  } in_item_t;

  typedef struct packed {
    logic               success;
    logic               neighbour_valid;
    logic [LABEL_W-1:0] region_label;
    logic               range_error;
  } out_item_t;

  // Effective grid geometry handed to the sequencer.
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [CNT_W-1:0] count;
  } geom_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVIDE,
    ST_RD_POS,
    ST_RD_NB,
    ST_CHECK,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // A dimension of zero acts as one, and anything above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(DIM_MAX)) begin
      r = DIM_W'(DIM_MAX);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/mzd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module mzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/mzd_rem.sv
// Iterative restoring remainder unit: one quotient bit per cycle, gives the cell column.
// Depends on mzd_pkg.
module mzd_rem
  import mzd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [POS_W-1:0] dividend,
  input  logic [DIM_W-1:0] divisor,
  output logic             done,
  output logic [DIM_W-1:0] remainder
);

  logic [REM_STEP_W-1:0] steps;
  logic [POS_W-1:0]      shift;
  logic [DIM_W-1:0]      div_q;
  logic [DIM_W:0]        trial;

  // Bring down the next dividend bit beside the partial remainder.
  assign trial = {remainder, shift[POS_W-1]};

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (start) begin
      steps <= REM_STEP_W'(POS_W);
      done  <= 1'b0;
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
      done  <= (steps == REM_STEP_W'(1));
    end else begin
      done  <= 1'b0;
    end
  end

  // Shared compare and subtract, one step per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      shift     <= dividend;
      div_q     <= divisor;
      remainder <= '0;
    end else if (steps != '0) begin
      shift <= {shift[POS_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        remainder <= DIM_W'(trial - {1'b0, div_q});
      end else begin
        remainder <= DIM_W'(trial);
      end
    end
  end

endmodule

// File: hw/rtl/mzd_ctrl.sv
// Sequencer for the maze block: clearing pass, column divide, door update and label scan.
// Depends on mzd_pkg, mzd_ram and mzd_rem.
module mzd_ctrl
  import mzd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  geom_t     geom,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res
);

  state_t state, state_next;

  logic             cmd_q;
  logic [POS_W-1:0] pos_q;
  dir_t             dir_q;
  logic             range_q;
  logic             ok_q;
  logic [CELL_AW-1:0] mine_q;
  logic [CELL_AW-1:0] theirs_q;
  logic [DOOR_W-1:0]  door_q;
  logic [CNT_W-1:0]   scan_idx;
  logic [CNT_W-1:0]   scan_prev;

  logic             in_range;
  logic             rem_start;
  logic             rem_done;
  logic [DIM_W-1:0] col;

  logic [SUM_W-1:0] pos_s, w_s, n_s, nb_s;
  logic             nb_valid;
  logic             door_at_nb;
  logic [DOOR_W-1:0]  door_mask;
  logic [CELL_AW-1:0] pos_addr, nb_addr, door_addr;
  logic               do_open;

  logic               label_we;
  logic [CELL_AW-1:0] label_waddr, label_wdata, label_raddr, label_rdata;
  logic               door_we;
  logic [DOOR_W-1:0]  door_wdata, door_rdata;

  // Position check against the cell count at the input transfer.
  assign in_range = SUM_W'(item.cell_pos) < SUM_W'(geom.count);

  mzd_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (item.cell_pos),
    .divisor   (geom.width),
    .done      (rem_done),
    .remainder (col)
  );

  // Neighbour and door selection from position, direction and column.
  always_comb begin
    pos_s      = SUM_W'(pos_q);
    w_s        = SUM_W'(geom.width);
    n_s        = SUM_W'(geom.count);
    nb_valid   = 1'b0;
    nb_s       = pos_s;
    door_at_nb = 1'b0;
    door_mask  = DOOR_MASK_RIGHT;
    case (dir_q)
      DIR_TOP: begin
        nb_valid   = pos_s >= w_s;
        nb_s       = pos_s - w_s;
        door_at_nb = 1'b1;
        door_mask  = DOOR_MASK_BOTTOM;
      end
      DIR_RIGHT: begin
        nb_valid   = (col != geom.width - 1'b1) && (pos_s + 1'b1 < n_s);
        nb_s       = pos_s + 1'b1;
      end
      DIR_BOTTOM: begin
        nb_valid   = pos_s + w_s < n_s;
        nb_s       = pos_s + w_s;
        door_mask  = DOOR_MASK_BOTTOM;
      end
      default: begin
        nb_valid   = col != '0;
        nb_s       = pos_s - 1'b1;
        door_at_nb = 1'b1;
      end
    endcase
  end

  assign pos_addr  = CELL_AW'(pos_q);
  assign nb_addr   = CELL_AW'(nb_s);
  assign door_addr = door_at_nb ? nb_addr : pos_addr;
  assign do_open   = nb_valid && (cmd_q == CMD_OPEN);
  assign scan_prev = scan_idx - 1'b1;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (scan_idx == CNT_W'(MAX_CELLS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid) state_next = in_range ? ST_DIVIDE : ST_RESULT;
      end
      ST_DIVIDE: begin
        if (rem_done) state_next = ST_RD_POS;
      end
      ST_RD_POS: state_next = ST_RD_NB;
      ST_RD_NB:  state_next = ST_CHECK;
      ST_CHECK: begin
        state_next = (do_open && (label_rdata != mine_q)) ? ST_SCAN : ST_RESULT;
      end
      ST_SCAN: begin
        if (scan_idx == CNT_W'(MAX_CELLS)) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Memory controls, unit start and handshakes.
  always_comb begin
    item_ready  = 1'b0;
    res_valid   = 1'b0;
    rem_start   = 1'b0;
    label_we    = 1'b0;
    label_waddr = scan_idx[CELL_AW-1:0];
    label_wdata = scan_idx[CELL_AW-1:0];
    label_raddr = pos_addr;
    door_we     = 1'b0;
    door_wdata  = '0;
    unique case (state)
      ST_CLEAR: begin
        label_we = 1'b1;
        door_we  = 1'b1;
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        rem_start  = item_valid && in_range;
      end
      ST_RD_NB: begin
        label_raddr = nb_addr;
      end
      ST_CHECK: begin
        door_we    = do_open;
        door_wdata = door_q | door_mask;
      end
      ST_SCAN: begin
        label_raddr = scan_idx[CELL_AW-1:0];
        label_we    = (scan_idx != '0) && (label_rdata == theirs_q);
        label_waddr = scan_prev[CELL_AW-1:0];
        label_wdata = mine_q;
      end
      ST_RESULT: begin
        res_valid = 1'b1;
      end
      default: begin
        label_raddr = pos_addr;
      end
    endcase
  end

  mzd_ram #(.WIDTH(CELL_AW), .DEPTH(MAX_CELLS)) u_label_ram (
    .clk   (clk),
    .we    (label_we),
    .waddr (label_waddr),
    .wdata (label_wdata),
    .raddr (label_raddr),
    .rdata (label_rdata)
  );

  mzd_ram #(.WIDTH(DOOR_W), .DEPTH(MAX_CELLS)) u_door_ram (
    .clk   (clk),
    .we    (door_we),
    .waddr ((state == ST_CLEAR) ? scan_idx[CELL_AW-1:0] : door_addr),
    .wdata (door_wdata),
    .raddr (door_addr),
    .rdata (door_rdata)
  );

  // Sweep counter, shared by the clearing pass and the relabel scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (state == ST_CLEAR || state == ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end else if (state == ST_CHECK) begin
      scan_idx <= '0;
    end
  end

  // Item and working registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      cmd_q   <= item.cmd;
      pos_q   <= item.cell_pos;
      dir_q   <= item.move_dir;
      range_q <= !in_range;
    end
    if (state == ST_RD_NB) begin
      mine_q <= label_rdata;
      door_q <= door_rdata;
    end
    if (state == ST_CHECK) begin
      theirs_q <= label_rdata;
      ok_q     <= nb_valid && ((cmd_q == CMD_OPEN) ||
                  ((cmd_q == CMD_QUERY) && ((door_q & door_mask) != '0)));
    end
  end

  // Result fields.
  always_comb begin
    if (range_q) begin
      res.success         = 1'b0;
      res.neighbour_valid = 1'b0;
      res.region_label    = '0;
      res.range_error     = 1'b1;
    end else begin
      res.success         = ok_q;
      res.neighbour_valid = nb_valid;
      res.region_label    = LABEL_W'(mine_q);
      res.range_error     = 1'b0;
    end
  end

endmodule

// File: hw/rtl/grid_maze_door_set_merge_top.sv
// Top level of the maze door set merge block: configuration, geometry and result register.
// Depends on mzd_pkg and mzd_ctrl.
//
//   channel   signals                        transfer when
//   input     in_valid, in_ready, in_data    in_valid && in_ready
//   output    out_valid, out_ready, out_data out_valid && out_ready
//   config    cfg_we, cfg_index, cfg_data    cfg_we
//
// After reset a clearing pass over all MAX_CELLS (1024) cells sets every label to its
// own index and closes every door; in_ready stays low meanwhile.
// An out-of-grid position goes straight to the result; any other item first runs
// the 10-step column divide. An open that merges two regions adds a label scan
// over all MAX_CELLS entries of the single label memory.
// One item is in work at a time; a waiting result sits in the output register
// while the next item is accepted, and the sequencer holds its result until the
// register frees up.
module grid_maze_door_set_merge_top
  import mzd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic [DIM_W-1:0]  grid_width;
  logic [DIM_W-1:0]  grid_height;
  logic [DIM_W-1:0]  w_cl, h_cl;
  logic [PROD_W-1:0] prod;
  geom_t             geom;

  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_W'(DIM_MAX);
      grid_height <= DIM_W'(DIM_MAX);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective geometry: clamped dimensions and the capped cell count.
  always_comb begin
    w_cl       = clamp_dim(grid_width);
    h_cl       = clamp_dim(grid_height);
    prod       = PROD_W'(w_cl) * PROD_W'(h_cl);
    geom.width = w_cl;
    geom.count = (32'(prod) > 32'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : CNT_W'(prod);
  end

  mzd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .geom       (geom),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item       (in_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Output register parts the sequencer from the output channel.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  // An out-of-grid result carries nothing but its flag.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.range_error) |->
      (!out_data.success && !out_data.neighbour_valid && out_data.region_label == '0))
    else $error("range error result carries other fields");

  // A door can only be opened or found open toward a neighbour inside the grid.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.success) |-> out_data.neighbour_valid)
    else $error("success without a valid neighbour");

  // The sequencer takes one item at a time.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in work");

endmodule

// File: bench/grid_maze_door_set_merge_top_tb.sv
// Self-checking testbench for grid_maze_door_set_merge_top: directed and random
// open and query commands over several grid sizes, checked against a cycle-free predictor.
// Depends on mzd_pkg and the RTL of the block.
import mzd_pkg::*;

// Mirrors the door and label stores and keeps the results still owed by the block.
class door_scoreboard;
  bit                 bottom_open [MAX_CELLS];
  bit                 right_open [MAX_CELLS];
  logic [LABEL_W-1:0] label_of [MAX_CELLS];
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  out_item_t          owed_q[$];
  int unsigned        errors;

  function new();
    for (int i = 0; i < MAX_CELLS; i++) begin
      bottom_open[i] = 1'b0;
      right_open[i] = 1'b0;
      label_of[i] = LABEL_W'(i);
    end
    width_reg = DIM_W'(32);
    height_reg = DIM_W'(32);
    errors = 0;
  endfunction

  // A dimension of zero counts as one, anything past 32 counts as 32.
  function int unsigned usable_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > 32) return 32;
    return v;
  endfunction

  function int unsigned cell_total();
    int unsigned n;
    n = usable_dim(width_reg) * usable_dim(height_reg);
    return (n > MAX_CELLS) ? MAX_CELLS : n;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
    if (idx == REG_GRID_WIDTH) begin
      width_reg = v;
    end else begin
      height_reg = v;
    end
  endfunction

  function int unsigned owed_count();
    return owed_q.size();
  endfunction

  // Applies one accepted command to the mirrored grid and queues its result.
  function void note_input(in_item_t it);
    int unsigned        w;
    int unsigned        n;
    int unsigned        pos;
    int unsigned        nb;
    int unsigned        col;
    bit                 nb_ok;
    bit                 ok;
    logic [LABEL_W-1:0] mine;
    logic [LABEL_W-1:0] theirs;
    out_item_t          r;
    w = usable_dim(width_reg);
    n = cell_total();
    pos = it.cell_pos;
    r = '0;
    if (pos >= n) begin
      r.range_error = 1'b1;
    end else begin
      col = pos % w;
      nb_ok = 1'b0;
      nb = 0;
      ok = 1'b0;
      case (it.move_dir)
        DIR_TOP: begin
          if (pos >= w) begin
            nb_ok = 1'b1;
            nb = pos - w;
          end
        end
        DIR_RIGHT: begin
          if (col != w - 1 && pos + 1 < n) begin
            nb_ok = 1'b1;
            nb = pos + 1;
          end
        end
        DIR_BOTTOM: begin
          if (pos + w < n) begin
            nb_ok = 1'b1;
            nb = pos + w;
          end
        end
        default: begin
          if (col != 0) begin
            nb_ok = 1'b1;
            nb = pos - 1;
          end
        end
      endcase
      if (nb_ok) begin
        if (it.cmd == CMD_OPEN) begin
          case (it.move_dir)
            DIR_TOP:    bottom_open[nb] = 1'b1;
            DIR_RIGHT:  right_open[pos] = 1'b1;
            DIR_BOTTOM: bottom_open[pos] = 1'b1;
            default:    right_open[nb] = 1'b1;
          endcase
          // Merge the neighbour's region into this cell's region.
          mine = label_of[pos];
          theirs = label_of[nb];
          if (mine != theirs) begin
            for (int i = 0; i < MAX_CELLS; i++) begin
              if (label_of[i] == theirs) label_of[i] = mine;
            end
          end
          ok = 1'b1;
        end else begin
          case (it.move_dir)
            DIR_TOP:    ok = bottom_open[nb];
            DIR_RIGHT:  ok = right_open[pos];
            DIR_BOTTOM: ok = bottom_open[pos];
            default:    ok = right_open[nb];
          endcase
        end
      end
      r.success = ok;
      r.neighbour_valid = nb_ok;
      r.region_label = label_of[pos];
    end
    owed_q.insert(owed_q.size(), r);
  endfunction

  // Compares one result transfer with the oldest owed result.
  function void check_result(out_item_t got);
    out_item_t want;
    if (owed_q.size() == 0) begin
      $error("result transfer with nothing owed: %p", got);
      errors++;
      return;
    end
    want = owed_q.pop_front();
    if (got.success !== want.success) begin
      $error("success: expected %0d, actual %0d", want.success, got.success);
      errors++;
    end
    if (got.neighbour_valid !== want.neighbour_valid) begin
      $error("neighbour_valid: expected %0d, actual %0d",
             want.neighbour_valid, got.neighbour_valid);
      errors++;
    end
    if (got.region_label !== want.region_label) begin
      $error("region_label: expected %0d, actual %0d", want.region_label, got.region_label);
      errors++;
    end
    if (got.range_error !== want.range_error) begin
      $error("range_error: expected %0d, actual %0d", want.range_error, got.range_error);
      errors++;
    end
  endfunction
endclass

module grid_maze_door_set_merge_top_tb;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int          PHASES      = 9;
  localparam int          PHASE_ITEMS = 62;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_WIDTH;
  logic [DIM_W-1:0]     cfg_data = '0;

  door_scoreboard sb;
  bit             idle_on = 1'b1;
  int unsigned    stall_left = 0;
  int unsigned    cycle_count = 0;

  // Grid sizes of the random phases; the last phase picks its own.
  int unsigned phase_w[8] = '{63, 1, 3, 7, 2, 40, 0, 32};
  int unsigned phase_h[8] = '{0, 1, 3, 5, 17, 20, 9, 32};

  grid_maze_door_set_merge_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Checks each result transfer and, while idling is on, stalls the output side in random bursts.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 18);
    end
    out_ready <= (stall_left == 0);
  end

  // Ends a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sends one command, after an optional gap, and records it once transferred.
  task automatic issue_cmd(logic c, int unsigned p, dir_t d);
    in_item_t it;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    it.cmd = c;
    it.cell_pos = POS_W'(p);
    it.move_dir = d;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  // Lowers valid and holds off until every owed result has been transferred.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.owed_count() != 0) @(posedge clk);
  endtask

  // Writes both grid dimensions; only called while the block is idle.
  task automatic set_grid(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= w;
    sb.set_reg(REG_GRID_WIDTH, w);
    @(posedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data <= h;
    sb.set_reg(REG_GRID_HEIGHT, h);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned n;
    int unsigned p;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // The clearing pass keeps in_ready low.
    do @(posedge clk); while (!in_ready);

    // Directed commands on the full 32 by 32 grid from reset.
    issue_cmd(CMD_QUERY, 0, DIR_TOP);
    issue_cmd(CMD_QUERY, 0, DIR_LEFT);
    issue_cmd(CMD_OPEN, 0, DIR_RIGHT);
    issue_cmd(CMD_OPEN, 0, DIR_BOTTOM);
    issue_cmd(CMD_QUERY, 0, DIR_RIGHT);
    issue_cmd(CMD_QUERY, 1, DIR_LEFT);
    issue_cmd(CMD_QUERY, 32, DIR_TOP);
    issue_cmd(CMD_QUERY, 0, DIR_BOTTOM);
    issue_cmd(CMD_OPEN, 1, DIR_BOTTOM);
    // Both cells already share a region, so the door opens without a relabel.
    issue_cmd(CMD_OPEN, 32, DIR_RIGHT);
    issue_cmd(CMD_QUERY, 33, DIR_LEFT);
    issue_cmd(CMD_QUERY, 31, DIR_RIGHT);
    issue_cmd(CMD_OPEN, 1023, DIR_BOTTOM);
    issue_cmd(CMD_OPEN, 1023, DIR_RIGHT);
    issue_cmd(CMD_OPEN, 1023, DIR_LEFT);
    issue_cmd(CMD_OPEN, 992, DIR_TOP);
    issue_cmd(CMD_QUERY, 1023, DIR_TOP);

    // Out-of-range dimensions give a single column of 32 rows; doors and labels persist.
    drain_results();
    set_grid(6'd0, 6'd63);
    issue_cmd(CMD_QUERY, 40, DIR_TOP);
    issue_cmd(CMD_OPEN, 1023, DIR_TOP);
    issue_cmd(CMD_OPEN, 5, DIR_RIGHT);
    issue_cmd(CMD_OPEN, 31, DIR_BOTTOM);
    issue_cmd(CMD_OPEN, 31, DIR_TOP);
    issue_cmd(CMD_QUERY, 1, DIR_TOP);

    // Random phases, each on its own grid size; the last one runs without idling.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      if (ph < 8) begin
        set_grid(DIM_W'(phase_w[ph]), DIM_W'(phase_h[ph]));
      end else begin
        set_grid(DIM_W'($urandom_range(0, 63)), DIM_W'($urandom_range(0, 63)));
      end
      idle_on = (ph != PHASES - 1) && ($urandom_range(0, 2) != 0);
      n = sb.cell_total();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Most positions land inside the grid; the rest sweep the whole field.
        if ($urandom_range(0, 99) < 85) begin
          p = $urandom_range(0, n - 1);
        end else begin
          p = $urandom_range(0, 1023);
        end
        issue_cmd(1'($urandom_range(0, 1)), p, dir_t'($urandom_range(0, 3)));
      end
    end

    drain_results();
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.owed_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
